FILE: sv/rodcut_pkg.sv
// ----------------------------------------------------------------------------
// rodcut_pkg
// Shared sizes and types for the rod cutting best-profit block.
// ----------------------------------------------------------------------------
package rodcut_pkg;

    // longest rod held in the stores
    localparam int MAX_LEN     = 64;
    // bits of one price
    localparam int PRICE_WIDTH = 16;

    // store address width and counter width (counter holds MAX_LEN itself)
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    // best[i] <= MAX_LEN * max price, so this width never wraps
    localparam int BEST_W   = PRICE_WIDTH + $clog2(MAX_LEN) + 1;
    // reported profit width, saturates above
    localparam int PROFIT_W = 22;

    // port widths: fields packed from bit 0, padded to whole bytes
    localparam int S_TDATA_W = ((PRICE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((PROFIT_W + 7) / 8) * 8;

    // control sequence
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CALC,
        ST_FLUSH,
        ST_DONE
    } state_t;

endpackage

FILE: sv/rodcut_ram.sv
// ----------------------------------------------------------------------------
// rodcut_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module rodcut_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/rod_cutting_max_profit.sv
// ----------------------------------------------------------------------------
// rod_cutting_max_profit
// Stores one price per request, then fills the best-profit table for lengths
// 1..n from a price RAM and a best RAM and returns best[n].
// ----------------------------------------------------------------------------
// Prices are taken one per cycle while loading; no price is taken after the request
// marked tlast until the result is loaded into the output register. The table
// issues one RAM read pair per candidate cut, then the read stage drains and the
// output register is loaded with best[n].
// Synchronous active-low reset clears the sequencer, counters and valids;
// both RAMs hold no reset contents and their read data is only used once written.
module rod_cutting_max_profit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // price request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rodcut_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] price
    input  logic                                s_tlast,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rodcut_pkg::M_TDATA_W-1:0]    m_tdata,   // [21:0] max_profit
    output logic [0:0]                          m_tuser    // [0] too_long
);

    localparam int AW = rodcut_pkg::ADDR_W;
    localparam int CW = rodcut_pkg::CNT_W;
    localparam int BW = rodcut_pkg::BEST_W;
    localparam int PW = rodcut_pkg::PRICE_WIDTH;
    localparam int OW = rodcut_pkg::PROFIT_W;
    localparam int M_TDATA_PAD = rodcut_pkg::M_TDATA_W;

    rodcut_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;

    // read stage tags
    logic          rd_vld_reg;
    logic          rd_first_reg;
    logic          rd_last_reg;
    logic [CW-1:0] rd_i_reg;

    logic [BW-1:0] top_reg;
    logic          m_tvalid_reg;
    logic [OW-1:0] m_profit_reg;
    logic          m_too_long_reg;

    logic          s_accept;
    logic          full;
    logic          issue;
    logic          load_out;
    logic          out_free;

    logic          price_we;
    logic [AW-1:0] price_raddr;
    logic [PW-1:0] price_rdata;
    logic          best_we;
    logic [AW-1:0] best_waddr;
    logic [AW-1:0] best_raddr;
    logic [BW-1:0] best_rdata;
    logic [BW-1:0] cand;
    logic [BW-1:0] top_now;
    logic [CW-1:0] jm1;
    logic [CW-1:0] ijm1;

    assign s_accept = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(rodcut_pkg::MAX_LEN));
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rodcut_pkg::ST_LOAD: begin
                if (s_accept && s_tlast) begin
                    state_next = rodcut_pkg::ST_CALC;
                end
            end
            rodcut_pkg::ST_CALC: begin
                if ((j_reg == CW'(1)) && (i_reg == n_reg)) begin
                    state_next = rodcut_pkg::ST_FLUSH;
                end
            end
            rodcut_pkg::ST_FLUSH: begin
                state_next = rodcut_pkg::ST_DONE;
            end
            rodcut_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = rodcut_pkg::ST_LOAD;
                end
            end
            default: state_next = rodcut_pkg::ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            rodcut_pkg::ST_LOAD:  s_tready = 1'b1;
            rodcut_pkg::ST_CALC:  issue    = 1'b1;
            rodcut_pkg::ST_FLUSH: ;
            rodcut_pkg::ST_DONE:  load_out = out_free;
            default: ;
        endcase
    end

    // price counting and cut loop indexes; j runs from i down to 1
    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        if (s_accept) begin
            if (full) begin
                ovf_next = 1'b1;
            end
            if (s_tlast) begin
                count_next = '0;
                n_next     = full ? count_reg : count_reg + CW'(1);
                i_next     = CW'(1);
                j_next     = CW'(1);
            end else if (!full) begin
                count_next = count_reg + CW'(1);
            end
        end
        if (issue) begin
            if (j_reg == CW'(1)) begin
                i_next = i_reg + CW'(1);
                j_next = i_reg + CW'(1);
            end else begin
                j_next = j_reg - CW'(1);
            end
        end
        if (load_out) begin
            ovf_next = 1'b0;
        end
    end

    // price RAM: written while loading, read at j-1 during the table fill
    assign price_we    = s_accept && !full;
    assign jm1         = j_reg - CW'(1);
    assign price_raddr = jm1[AW-1:0];

    rodcut_ram #(
        .WIDTH (PW),
        .DEPTH (rodcut_pkg::MAX_LEN)
    ) u_price_ram (
        .aclk  (aclk),
        .we    (price_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata[PW-1:0]),
        .raddr (price_raddr),
        .rdata (price_rdata)
    );

    // best RAM: best[k] lives at k-1, best[0] is the constant zero
    assign ijm1       = i_reg - j_reg - CW'(1);
    assign best_raddr = ijm1[AW-1:0];

    rodcut_ram #(
        .WIDTH (BW),
        .DEPTH (rodcut_pkg::MAX_LEN)
    ) u_best_ram (
        .aclk  (aclk),
        .we    (best_we),
        .waddr (best_waddr),
        .wdata (top_now),
        .raddr (best_raddr),
        .rdata (best_rdata)
    );

    // compare stage: running maximum over the cuts of one length
    assign cand    = BW'(price_rdata) + (rd_first_reg ? '0 : best_rdata);
    assign top_now = (rd_first_reg || (cand > top_reg)) ? cand : top_reg;

    // write back best[i] after its smallest cut; read of it comes later
    logic [CW-1:0] rd_im1;
    assign rd_im1     = rd_i_reg - CW'(1);
    assign best_we    = rd_vld_reg && rd_last_reg;
    assign best_waddr = rd_im1[AW-1:0];

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rodcut_pkg::ST_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            rd_vld_reg <= issue;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        rd_first_reg <= (j_reg == i_reg);
        rd_last_reg  <= (j_reg == CW'(1));
        rd_i_reg     <= i_reg;
        if (rd_vld_reg) begin
            top_reg <= top_now;
        end
        if (load_out) begin
            m_profit_reg   <= (top_reg > BW'({OW{1'b1}})) ? {OW{1'b1}} : top_reg[OW-1:0];
            m_too_long_reg <= ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_PAD'(m_profit_reg);
    assign m_tuser  = m_too_long_reg;

    // the drain cycle always carries the final cut of length n
    a_flush_final : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rodcut_pkg::ST_FLUSH) |->
            (rd_vld_reg && rd_last_reg && (rd_i_reg == n_reg)))
        else $error("drain cycle without final cut of the rod");

    // best writes stay inside the current rod
    a_best_range : assert property (@(posedge aclk) disable iff (!aresetn)
        best_we |-> ((rd_i_reg != '0) && (rd_i_reg <= n_reg)))
        else $error("best write outside rod length");

    // price count never passes the store depth
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(rodcut_pkg::MAX_LEN))
        else $error("price count beyond store depth");

    // a result only appears after the table is done
    a_result_src : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == rodcut_pkg::ST_DONE))
        else $error("result raised outside done state");

endmodule

FILE: bench/tb_rod_cutting_max_profit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rod_cutting_max_profit
// Streams rods of prices into the best-profit block and checks every answer
// against a cut-table model kept in the bench or a pinned value. A short table
// of hand-picked rods (single pieces, full and overlong rods, extreme prices)
// comes first, then random rods of mostly short lengths with random gaps on
// both sides, one long output stall and one pause that lets the block drain.
// ----------------------------------------------------------------------------
module tb_rod_cutting_max_profit;

    localparam int MAX_LEN      = rodcut_pkg::MAX_LEN;
    localparam int PRICE_WIDTH  = rodcut_pkg::PRICE_WIDTH;
    localparam int BEST_W       = rodcut_pkg::BEST_W;
    localparam int PROFIT_W     = rodcut_pkg::PROFIT_W;
    localparam int S_TDATA_W    = rodcut_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = rodcut_pkg::M_TDATA_W;

    localparam int RAND_PRICES  = 1000;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 2200;
    localparam int LONG_HOLD    = 6000;
    localparam int MAX_REPORTS  = 10;
    localparam logic [BEST_W-1:0] PROFIT_MAX = (BEST_W'(1) << PROFIT_W) - BEST_W'(1);

    // one answer of the block
    typedef struct packed {
        logic [PROFIT_W-1:0] profit;
        logic                too_long;
    } rod_answer_t;

    // one row of the directed rods: price repeated reps times
    typedef struct {
        logic [15:0]         price;
        int                  reps;
        bit                  last;
        bit                  pinned;
        logic [PROFIT_W-1:0] profit;
        bit                  too_long;
    } price_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;   // [15:0] price
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;   // [21:0] max_profit
    logic [0:0]              m_tuser;   // [0] too_long

    // rod model state
    logic [PRICE_WIDTH-1:0]  rod_prices [MAX_LEN];
    int                      rod_count = 0;
    bit                      rod_spill = 1'b0;

    rod_answer_t             answer_q [$];
    int                      fail_count = 0;
    int                      cycle_count = 0;
    int                      prices_sent = 0;
    int                      hold_req = 0;

    price_row_t dir_rows [18] = '{
        '{16'h0000,  1, 1'b1, 1'b1, 22'd0,       1'b0},  // one zero piece
        '{16'hFFFF,  1, 1'b1, 1'b1, 22'd65535,   1'b0},  // one top-price piece
        '{16'd1,     1, 1'b0, 1'b0, 22'd0,       1'b0},
        '{16'd3,     1, 1'b1, 1'b0, 22'd0,       1'b0},  // whole beats two halves
        '{16'd10,    1, 1'b0, 1'b0, 22'd0,       1'b0},
        '{16'd5,     1, 1'b0, 1'b0, 22'd0,       1'b0},
        '{16'd8,     1, 1'b1, 1'b0, 22'd0,       1'b0},  // short cuts beat whole
        '{16'hFFFF, 64, 1'b1, 1'b1, 22'd4194240, 1'b0},  // full rod, top prices
        '{16'h0000, 64, 1'b1, 1'b1, 22'd0,       1'b0},  // full rod, all free
        '{16'hFFFF, 65, 1'b1, 1'b1, 22'd4194240, 1'b1},  // last price is an extra
        '{16'd7,    70, 1'b0, 1'b0, 22'd0,       1'b0},
        '{16'd9,     1, 1'b1, 1'b1, 22'd448,     1'b1},  // extras ahead of last
        '{16'h5555,  1, 1'b0, 1'b0, 22'd0,       1'b0},
        '{16'hAAAA,  1, 1'b1, 1'b0, 22'd0,       1'b0},  // alternating bits
        '{16'h8000,  2, 1'b0, 1'b0, 22'd0,       1'b0},
        '{16'h0001,  1, 1'b1, 1'b0, 22'd0,       1'b0},
        '{16'h0001, 63, 1'b1, 1'b0, 22'd0,       1'b0},  // one short of full
        '{16'h7FFF,  3, 1'b1, 1'b0, 22'd0,       1'b0}
    };

    rod_cutting_max_profit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always #1 aclk = ~aclk;

    // store one price; on the last one fill the cut table and give best[n]
    function automatic bit rod_take_price(input logic [PRICE_WIDTH-1:0] price,
                                          input logic last, output rod_answer_t res);
        bit [BEST_W-1:0] best_tbl [MAX_LEN+1];
        bit [BEST_W-1:0] cand;
        int              n;
        res = '0;
        if (rod_count < MAX_LEN) begin
            rod_prices[rod_count] = price;
            rod_count++;
        end else begin
            rod_spill = 1'b1;
        end
        if (!last)
            return 1'b0;
        n = rod_count;
        best_tbl[0] = '0;
        for (int i = 1; i <= n; i++) begin
            best_tbl[i] = '0;
            for (int j = 1; j <= i; j++) begin
                cand = BEST_W'(rod_prices[j-1]) + best_tbl[i-j];
                if (cand > best_tbl[i])
                    best_tbl[i] = cand;
            end
        end
        res.profit   = (best_tbl[n] > PROFIT_MAX) ? PROFIT_MAX[PROFIT_W-1:0]
                                                  : best_tbl[n][PROFIT_W-1:0];
        res.too_long = rod_spill;
        rod_count = 0;
        rod_spill = 1'b0;
        return 1'b1;
    endfunction

    task automatic note_failure(input string what, input logic [31:0] expv,
                                input logic [31:0] actv);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s expected %h got %h",
                     cycle_count, what, expv, actv);
    endtask

    // offer one price request after the given idle gap, wait for acceptance
    task automatic send_price(input logic [15:0] price, input logic last, input int gap,
                              input bit pinned, input rod_answer_t pinned_res);
        rod_answer_t res;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(price);
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        prices_sent++;
        if (rod_take_price(price[PRICE_WIDTH-1:0], last, res))
            answer_q.push_back(pinned ? pinned_res : res);
    endtask

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        rod_answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (answer_q.size() == 0) begin
                note_failure("unexpected result, tdata", '0, 32'(m_tdata));
            end else begin
                want = answer_q.pop_front();
                if (m_tdata !== M_TDATA_W'(want.profit))
                    note_failure("max_profit", 32'(want.profit), 32'(m_tdata));
                if (m_tuser[0] !== want.too_long)
                    note_failure("too_long", 32'(want.too_long), 32'(m_tuser[0]));
            end
        end
    end

    // result receiver with random stalls, bursts of no stall and one long hold
    initial begin
        int stall;
        bit ready_burst;
        ready_burst = 1'b0;
        m_tready <= 1'b0;
        forever begin
            if (hold_req > 0) begin
                stall = hold_req;
                hold_req = 0;
            end else begin
                stall = ready_burst ? 0 : $urandom_range(0, 9);
            end
            if ($urandom_range(0, 15) == 0)
                ready_burst = !ready_burst;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // stimulus
    initial begin
        rod_answer_t pin_res;
        rod_answer_t no_pin;
        int          rod_len;
        int          rod_idx;
        int          pick;
        int          spread;
        int          first_rand;
        bit          burst;
        logic [15:0] price;

        no_pin   = '0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rods
        foreach (dir_rows[r]) begin
            pin_res.profit   = dir_rows[r].profit;
            pin_res.too_long = dir_rows[r].too_long;
            for (int k = 0; k < dir_rows[r].reps; k++)
                send_price(dir_rows[r].price, dir_rows[r].last && (k == dir_rows[r].reps - 1),
                           $urandom_range(0, 9), dir_rows[r].pinned, pin_res);
        end

        // random rods, mostly short, a few full or overlong
        first_rand = prices_sent;
        rod_idx = 0;
        while (prices_sent - first_rand < RAND_PRICES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                rod_len = $urandom_range(1, 8);
            else if (pick < 90)
                rod_len = $urandom_range(9, 30);
            else if (pick < 97)
                rod_len = $urandom_range(31, MAX_LEN);
            else
                rod_len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
            case ($urandom_range(0, 2))
                0:       spread = 15;
                1:       spread = 255;
                default: spread = 65535;
            endcase
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < rod_len; k++) begin
                if ($urandom_range(0, 9) == 0)
                    price = 16'hFFFF - 16'($urandom_range(0, 255));
                else
                    price = 16'($urandom_range(0, spread));
                send_price(price, k == rod_len - 1, burst ? 0 : $urandom_range(0, 9),
                           1'b0, no_pin);
            end
            rod_idx++;
            // receiver holds off while requests keep coming
            if (rod_idx == 12)
                hold_req = LONG_HOLD;
            // let the block drain completely before going on
            if (rod_idx == 40) begin
                s_tvalid <= 1'b0;
                while (answer_q.size() != 0) @(posedge aclk);
                repeat (20) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        // wait out the last answers, then watch for strays
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        fail_count += answer_q.size();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
